>>> src/kwh_pkg.sv
// Shared types and constants of the keyword hash lookup block.
package kwh_pkg;

  typedef logic [2:0] kwh_status_t;

  localparam kwh_status_t ST_HIT      = 3'd0;
  localparam kwh_status_t ST_MISS     = 3'd1;
  localparam kwh_status_t ST_TOO_LONG = 3'd2;
  localparam kwh_status_t ST_FULL     = 3'd3;
  localparam kwh_status_t ST_INSERTED = 3'd4;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_KEY_WR,
    S_CMP_RD,
    S_CMP_CHK,
    S_RESULT
  } kwh_state_t;

endpackage

>>> src/kwh_in_if.sv
// Request channel of the keyword hash lookup block: one name byte per request.
interface kwh_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] name_byte;
  logic       last_byte;
  logic [7:0] opcode_value;

  modport source (output valid, mode, name_byte, last_byte, opcode_value, input ready);
  modport sink   (input valid, mode, name_byte, last_byte, opcode_value, output ready);
endinterface

>>> src/kwh_out_if.sv
// Result channel of the keyword hash lookup block.
interface kwh_out_if
  import kwh_pkg::*;
;
  logic        valid;
  logic        ready;
  kwh_status_t status;
  logic [7:0]  opcode;

  modport source (output valid, status, opcode, input ready);
  modport sink   (input valid, status, opcode, output ready);
endinterface

>>> src/keyword_hash_lookup_core.sv
// Keyword hash lookup: a linear-probing hash table mapping names to opcodes.
// A name arrives one byte per request, and after each byte but the last the block is
// ready for the next. After the final byte of a name that is not too long, the block
// walks the probe chain in its slot memory, reading and then checking each probed slot;
// an insert then writes one key byte per cycle and a lookup reads and then compares each
// stored key byte in turn, since the key memory has one read port with a registered
// output. The result is loaded into an output register once that register is free, and
// the next name is taken while that result still waits. After reset the block sweeps the
// slot memory to clear its valid marks, and no request is accepted during the sweep.
module keyword_hash_lookup_core
  import kwh_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int MAX_NAME   = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  kwh_in_if.sink     in_req,
  kwh_out_if.source  out_rsp
);

  localparam int SLW = $clog2(TABLE_SIZE);
  localparam int CW  = $clog2(MAX_NAME + 2);
  localparam int LW  = $clog2(MAX_NAME + 1);
  localparam int NIW = $clog2(MAX_NAME);
  localparam int KAW = $clog2(TABLE_SIZE * MAX_NAME);
  localparam int SW  = ((SLW > 8) ? SLW : 8) + 1;
  localparam int MW  = LW + 9;

  function automatic logic [SLW-1:0] mod_table(input logic [SW-1:0] v_in);
    logic [SW-1:0] v;
    logic [31:0]   t;
    v = v_in;
    for (int i = SW - 1; i >= 0; i--) begin
      t = 32'(TABLE_SIZE) << i;
      if (t < (32'd1 << SW) && 32'(v) >= t) begin
        v = v - SW'(t);
      end
    end
    return SLW'(v);
  endfunction

  kwh_state_t state_r, state_nxt;

  logic [CW-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [CW-1:0]  kept_r, kept_nxt;
  logic [SLW-1:0] hash_r, hash_nxt;
  logic           space_r, space_nxt;
  logic           mode_r, mode_nxt;
  logic [7:0]     opv_r, opv_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;
  logic [SLW-1:0] probe_n_r, probe_n_nxt;
  logic [NIW-1:0] k_r, k_nxt;
  logic [7:0]     opc_r, opc_nxt;
  kwh_status_t    res_status_r, res_status_nxt;
  logic [7:0]     res_opc_r, res_opc_nxt;
  logic           out_valid_r, out_valid_nxt;
  kwh_status_t    out_status_r, out_status_nxt;
  logic [7:0]     out_opc_r, out_opc_nxt;

  logic [7:0]     name_buf [MAX_NAME];
  logic [MW-1:0]  meta_mem [TABLE_SIZE];
  logic [7:0]     key_mem  [TABLE_SIZE * MAX_NAME];
  logic [MW-1:0]  meta_q_r;
  logic [7:0]     key_q_r;

  logic           in_fire, keep_byte, out_free;
  logic [CW-1:0]  cnt_upd;
  logic [SLW-1:0] hash_upd;
  logic           space_upd, too_long;
  logic           meta_valid;
  logic [LW-1:0]  meta_len;
  logic [7:0]     meta_opc;
  logic           len_match, kept_zero, wrap_end, k_last, key_match;
  logic [SLW-1:0] slot_inc;
  logic [KAW-1:0] key_addr;
  logic           meta_we;
  logic [MW-1:0]  meta_wd;
  logic           key_we;

  assign in_req.ready    = (state_r == S_IDLE);
  assign in_fire         = in_req.valid && in_req.ready;
  assign out_free        = !out_valid_r || out_rsp.ready;
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.status  = out_status_r;
  assign out_rsp.opcode  = out_opc_r;

  assign cnt_upd   = (byte_cnt_r <= CW'(MAX_NAME)) ? byte_cnt_r + CW'(1) : byte_cnt_r;
  assign keep_byte = !space_r && (in_req.name_byte != SPACE_CHAR) && (kept_r < CW'(MAX_NAME));
  assign space_upd = space_r || (in_req.name_byte == SPACE_CHAR);
  assign hash_upd  = keep_byte ? mod_table(SW'(hash_r) + SW'(in_req.name_byte)) : hash_r;
  assign too_long  = (cnt_upd > CW'(MAX_NAME));

  assign meta_valid = meta_q_r[MW-1];
  assign meta_len   = meta_q_r[LW+7:8];
  assign meta_opc   = meta_q_r[7:0];
  assign len_match  = (CW'(meta_len) == kept_r);
  assign kept_zero  = (kept_r == '0);
  assign wrap_end   = (probe_n_r == SLW'(TABLE_SIZE - 1));
  assign k_last     = ((CW'(k_r) + CW'(1)) == kept_r);
  assign key_match  = (key_q_r == name_buf[k_r]);
  assign slot_inc   = (slot_r == SLW'(TABLE_SIZE - 1)) ? '0 : slot_r + SLW'(1);
  assign key_addr   = KAW'(slot_r) * KAW'(MAX_NAME) + KAW'(k_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (slot_r == SLW'(TABLE_SIZE - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire && in_req.last_byte) begin
          state_nxt = too_long ? S_RESULT : S_PROBE_RD;
        end
      end
      S_PROBE_RD: state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!meta_valid) begin
          state_nxt = (!mode_r && !kept_zero) ? S_KEY_WR : S_RESULT;
        end else if (mode_r && len_match) begin
          state_nxt = kept_zero ? S_RESULT : S_CMP_RD;
        end else begin
          state_nxt = wrap_end ? S_RESULT : S_PROBE_RD;
        end
      end
      S_KEY_WR: begin
        if (k_last) state_nxt = S_RESULT;
      end
      S_CMP_RD: state_nxt = S_CMP_CHK;
      S_CMP_CHK: begin
        if (!key_match) begin
          state_nxt = wrap_end ? S_RESULT : S_PROBE_RD;
        end else begin
          state_nxt = k_last ? S_RESULT : S_CMP_RD;
        end
      end
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    byte_cnt_nxt   = byte_cnt_r;
    kept_nxt       = kept_r;
    hash_nxt       = hash_r;
    space_nxt      = space_r;
    mode_nxt       = mode_r;
    opv_nxt        = opv_r;
    slot_nxt       = slot_r;
    probe_n_nxt    = probe_n_r;
    k_nxt          = k_r;
    opc_nxt        = opc_r;
    res_status_nxt = res_status_r;
    res_opc_nxt    = res_opc_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_opc_nxt    = out_opc_r;
    meta_we        = 1'b0;
    meta_wd        = '0;
    key_we         = 1'b0;
    case (state_r)
      S_CLEAR: begin
        meta_we  = 1'b1;
        slot_nxt = slot_inc;
      end
      S_IDLE: begin
        if (in_fire) begin
          byte_cnt_nxt = cnt_upd;
          space_nxt    = space_upd;
          hash_nxt     = hash_upd;
          if (keep_byte) kept_nxt = kept_r + CW'(1);
          mode_nxt     = in_req.mode;
          opv_nxt      = in_req.opcode_value;
          slot_nxt     = hash_upd;
          probe_n_nxt  = '0;
          k_nxt        = '0;
          res_status_nxt = ST_TOO_LONG;
          res_opc_nxt    = '0;
        end
      end
      S_PROBE_CHK: begin
        if (!meta_valid) begin
          if (!mode_r) begin
            meta_we        = 1'b1;
            meta_wd        = {1'b1, LW'(kept_r), opv_r};
            res_status_nxt = ST_INSERTED;
          end else begin
            res_status_nxt = ST_MISS;
          end
        end else if (mode_r && len_match) begin
          opc_nxt = meta_opc;
          k_nxt   = '0;
          if (kept_zero) begin
            res_status_nxt = ST_HIT;
            res_opc_nxt    = meta_opc;
          end
        end else begin
          slot_nxt       = slot_inc;
          probe_n_nxt    = probe_n_r + SLW'(1);
          res_status_nxt = mode_r ? ST_MISS : ST_FULL;
        end
      end
      S_KEY_WR: begin
        key_we = 1'b1;
        k_nxt  = k_r + NIW'(1);
      end
      S_CMP_CHK: begin
        if (!key_match) begin
          slot_nxt       = slot_inc;
          probe_n_nxt    = probe_n_r + SLW'(1);
          k_nxt          = '0;
          res_status_nxt = ST_MISS;
        end else if (k_last) begin
          res_status_nxt = ST_HIT;
          res_opc_nxt    = opc_r;
        end else begin
          k_nxt = k_r + NIW'(1);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_opc_nxt    = res_opc_r;
          byte_cnt_nxt   = '0;
          kept_nxt       = '0;
          hash_nxt       = '0;
          space_nxt      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      byte_cnt_r  <= '0;
      kept_r      <= '0;
      hash_r      <= '0;
      space_r     <= 1'b0;
      slot_r      <= '0;
      probe_n_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      kept_r      <= kept_nxt;
      hash_r      <= hash_nxt;
      space_r     <= space_nxt;
      slot_r      <= slot_nxt;
      probe_n_r   <= probe_n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    opv_r        <= opv_nxt;
    opc_r        <= opc_nxt;
    res_status_r <= res_status_nxt;
    res_opc_r    <= res_opc_nxt;
    out_status_r <= out_status_nxt;
    out_opc_r    <= out_opc_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire && keep_byte) begin
      name_buf[kept_r[NIW-1:0]] <= in_req.name_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[slot_r] <= meta_wd;
    end
    meta_q_r <= meta_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_addr] <= name_buf[k_r];
    end
    key_q_r <= key_mem[key_addr];
  end

endmodule

>>> src/kwh_checker.sv
// Port-level checks of the keyword hash lookup block and their binding.
module kwh_checker
  import kwh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input kwh_status_t out_status,
  input logic [7:0]  out_opcode
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_opcode))
    else $error("Stalled result changed.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_HIT || out_status == ST_MISS ||
                   out_status == ST_TOO_LONG || out_status == ST_FULL ||
                   out_status == ST_INSERTED))
    else $error("Result status has no meaning.");

  a_opcode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_HIT |-> out_opcode == 8'd0)
    else $error("Opcode is not zero on a result other than a hit.");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("Request taken while a name is still being resolved.");

endmodule

bind keyword_hash_lookup_core kwh_checker u_kwh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_last    (in_req.last_byte),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_opcode (out_rsp.opcode)
);
